// File: rtl/core/btb_pkg.sv
// Shared constants and codes for the branch target buffer predictor.
`timescale 1ns / 1ps
`default_nettype none
package btb_pkg;
  localparam int HIST_MAX = 8;
  localparam int TAG_MAX  = 30;
  localparam int TBL_SIZE = 1 << HIST_MAX;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int ENTRY_W = TAG_MAX + 32 + HIST_MAX;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLOB_HIST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLOB_TABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE  = 3'd6;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  localparam logic [1:0] SHARE_LOW  = 2'd1;
  localparam logic [1:0] SHARE_HIGH = 2'd2;
endpackage
`default_nettype wire

// File: rtl/core/btb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module btb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/btb_two_level_branch_predictor_top.sv
// Top level of the branch target buffer with a two-level direction predictor.
`timescale 1ns / 1ps
`default_nettype none
// Each command beat reads the entry memory (tag, target, local history),
// then reads the counter memories at the index built from that history, and
// then updates and writes everything back. The result beat is shown on the
// result ports with done high for exactly one cycle, the first cycle in
// which busy is low again; the receiver cannot stall it, so it must take
// the beat then. A new command may be accepted at the end of that same
// cycle. The per entry counter tables live in one memory of BTB_DEPTH*256
// two-bit words; a row of 256 written-marks per entry is kept in a second
// memory and cleared in one write when an entry is allocated, so a counter
// that was not touched since allocation reads as the initial state stored
// for that entry. The shared table has one flip-flop mark per counter that
// reset and a write of the initial state register clear. No clearing pass
// is needed after reset.
// Configuration registers are written through wr_en/wr_index/wr_data and must
// only change while the block is idle.
module btb_two_level_branch_predictor_top #(
  parameter int BTB_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        cmd,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] actual_target,
  input  wire logic        was_taken,
  input  wire logic [31:0] predicted_dest,
  input  wire logic        wr_en,
  input  wire logic [btb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [btb_pkg::CFG_DATA_W-1:0] wr_data,
  output      logic        done,
  output      logic        predict_taken,
  output      logic [31:0] predict_dest,
  output      logic [31:0] flush_count,
  output      logic [31:0] branch_count
);
  localparam int SLOT_W = BTB_DEPTH > 1 ? $clog2(BTB_DEPTH) : 1;
  localparam int CNT_DEPTH = BTB_DEPTH * btb_pkg::TBL_SIZE;
  localparam int CNT_AW = CNT_DEPTH > 1 ? $clog2(CNT_DEPTH) : 1;
  localparam int HW = btb_pkg::HIST_MAX;
  localparam int TW = btb_pkg::TAG_MAX;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC} state_t;
  state_t state;

  // Configuration registers.
  logic [2:0] cfg_bits;
  logic [3:0] cfg_hlen;
  logic [4:0] cfg_tlen;
  logic [1:0] cfg_init;
  logic       cfg_ghist;
  logic       cfg_gtab;
  logic [1:0] cfg_share;

  // Latched command.
  logic              cmd_q;
  logic [31:0]       pc_q;
  logic [31:0]       act_q;
  logic              taken_q;
  logic [31:0]       pred_q;
  logic [SLOT_W-1:0] slot_q;

  // Values carried from the lookup cycle to the execute cycle.
  logic          hit_q;
  logic [HW-1:0] cidx_q;
  logic [HW-1:0] hsrc_q;
  logic [HW-1:0] ehist_q;
  logic [31:0]   etarget_q;

  logic [BTB_DEPTH-1:0]         entry_valid;
  logic [1:0]                   slot_init [BTB_DEPTH];
  logic [btb_pkg::TBL_SIZE-1:0] sh_valid;
  logic [HW-1:0]                shared_history;

  function automatic logic [SLOT_W-1:0] mod_depth(input logic [4:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v == 5'(i)) begin
        r = SLOT_W'(i % BTB_DEPTH);
      end
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_calc(input logic [31:0] a,
                                                  input logic [2:0] k);
    logic [4:0] v;
    v = a[6:2] & ~(5'h1f << k);
    return mod_depth(v);
  endfunction

  logic [2:0]    k_eff;
  logic [4:0]    t_eff;
  logic [HW-1:0] hmask;
  logic [3:0]    h_eff;

  always_comb begin
    k_eff = (cfg_bits > 3'd5) ? 3'd5 : cfg_bits;
    t_eff = (cfg_tlen > 5'(TW)) ? 5'(TW) : cfg_tlen;
    if (cfg_hlen == 4'd0) begin
      h_eff = 4'd1;
    end else if (cfg_hlen > 4'(HW)) begin
      h_eff = 4'(HW);
    end else begin
      h_eff = cfg_hlen;
    end
    hmask = {HW{1'b1}} >> (4'(HW) - h_eff);
  end

  // Entry memory: {tag, target, local history}.
  logic                        e_we;
  logic [SLOT_W-1:0]           e_raddr;
  logic [btb_pkg::ENTRY_W-1:0] e_wdata, e_rdata;
  logic [TW-1:0]               e_tag;
  logic [31:0]                 e_target;
  logic [HW-1:0]               e_hist;

  assign {e_tag, e_target, e_hist} = e_rdata;
  assign e_raddr = slot_calc(pc, k_eff);

  btb_ram #(.WIDTH(btb_pkg::ENTRY_W), .DEPTH(BTB_DEPTH)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(slot_q), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // Lookup cycle: tag compare and counter index.
  logic [TW-1:0] tag_l;
  logic          hit_l;
  logic [HW-1:0] hsrc_l, x_l, cidx_l;

  always_comb begin
    tag_l = (pc_q[31:2] >> k_eff) & ~({TW{1'b1}} << t_eff);
    hit_l = entry_valid[slot_q] && (e_tag == tag_l);
    if (cfg_ghist) begin
      hsrc_l = shared_history;
    end else if (cmd_q == btb_pkg::CMD_UPDATE && !hit_l) begin
      hsrc_l = '0;
    end else begin
      hsrc_l = e_hist;
    end
    case (cfg_share)
      btb_pkg::SHARE_LOW:  x_l = pc_q[2 +: HW];
      btb_pkg::SHARE_HIGH: x_l = pc_q[16 +: HW];
      default:             x_l = '0;
    endcase
    cidx_l = cfg_gtab ? ((x_l ^ hsrc_l) & hmask) : (hsrc_l & hmask);
  end

  // Counter memories.
  logic                         cnt_we, row_we, sh_we;
  logic [1:0]                   cnt_rdata, sh_rdata, cnt_new;
  logic [btb_pkg::TBL_SIZE-1:0] row_rdata, row_wdata, row_bit;

  btb_ram #(.WIDTH(2), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(CNT_AW'({slot_q, cidx_q})), .wdata(cnt_new),
    .raddr(CNT_AW'({slot_q, cidx_l})), .rdata(cnt_rdata)
  );

  btb_ram #(.WIDTH(btb_pkg::TBL_SIZE), .DEPTH(BTB_DEPTH)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(slot_q), .wdata(row_wdata),
    .raddr(slot_q), .rdata(row_rdata)
  );

  btb_ram #(.WIDTH(2), .DEPTH(btb_pkg::TBL_SIZE)) u_shared_ram (
    .clk(clk), .we(sh_we), .waddr(cidx_q), .wdata(cnt_new),
    .raddr(cidx_l), .rdata(sh_rdata)
  );

  // Execute cycle.
  logic          is_upd;
  logic [1:0]    cnt_old;
  logic [HW-1:0] hist_new, ehist_wr;
  logic          flush;
  logic [31:0]   next_pc;

  always_comb begin
    is_upd = (state == S_EXEC) && (cmd_q == btb_pkg::CMD_UPDATE);
    next_pc = pc_q + 32'd4;
    row_bit = btb_pkg::TBL_SIZE'(1) << cidx_q;
    if (cfg_gtab) begin
      cnt_old = sh_valid[cidx_q] ? sh_rdata : cfg_init;
    end else if (!hit_q) begin
      cnt_old = cfg_init;
    end else begin
      cnt_old = (row_rdata & row_bit) != '0 ? cnt_rdata : slot_init[slot_q];
    end
    if (taken_q) begin
      cnt_new = (cnt_old == 2'd3) ? cnt_old : cnt_old + 2'd1;
    end else begin
      cnt_new = (cnt_old == 2'd0) ? cnt_old : cnt_old - 2'd1;
    end
    hist_new = {hsrc_q[HW-2:0], taken_q} & hmask;
    if (cfg_ghist) begin
      ehist_wr = hit_q ? ehist_q : '0;
    end else begin
      ehist_wr = hist_new;
    end
    e_we    = is_upd;
    e_wdata = {tag_l, act_q, ehist_wr};
    cnt_we  = is_upd && !cfg_gtab;
    sh_we   = is_upd && cfg_gtab;
    row_we  = is_upd && (!cfg_gtab || !hit_q);
    if (cfg_gtab) begin
      row_wdata = '0;
    end else begin
      row_wdata = hit_q ? (row_rdata | row_bit) : row_bit;
    end
    if (hit_q) begin
      flush = (taken_q && act_q != pred_q) || (!taken_q && pred_q != next_pc);
    end else begin
      flush = taken_q && act_q != next_pc && act_q != pred_q;
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      cfg_bits       <= 3'd5;
      cfg_hlen       <= 4'd8;
      cfg_tlen       <= 5'd30;
      cfg_init       <= 2'd1;
      cfg_ghist      <= 1'b0;
      cfg_gtab       <= 1'b0;
      cfg_share      <= 2'd0;
      entry_valid    <= '0;
      sh_valid       <= '0;
      shared_history <= '0;
      flush_count    <= '0;
      branch_count   <= '0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          btb_pkg::REG_INDEX_BITS: cfg_bits  <= wr_data[2:0];
          btb_pkg::REG_HIST_LEN:   cfg_hlen  <= wr_data[3:0];
          btb_pkg::REG_TAG_LEN:    cfg_tlen  <= wr_data;
          btb_pkg::REG_INIT_STATE: begin
            cfg_init <= wr_data[1:0];
            sh_valid <= '0;
          end
          btb_pkg::REG_GLOB_HIST:  cfg_ghist <= wr_data[0];
          btb_pkg::REG_GLOB_TABLE: cfg_gtab  <= wr_data[0];
          btb_pkg::REG_SHARE_MODE: cfg_share <= wr_data[1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd;
            pc_q    <= pc;
            act_q   <= actual_target;
            taken_q <= was_taken;
            pred_q  <= predicted_dest;
            slot_q  <= e_raddr;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q     <= hit_l;
          cidx_q    <= cidx_l;
          hsrc_q    <= hsrc_l;
          ehist_q   <= e_hist;
          etarget_q <= e_target;
          state     <= S_EXEC;
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (cmd_q == btb_pkg::CMD_UPDATE) begin
            entry_valid[slot_q] <= 1'b1;
            if (!hit_q) begin
              slot_init[slot_q] <= cfg_init;
            end
            if (cfg_gtab) begin
              sh_valid[cidx_q] <= 1'b1;
            end
            if (cfg_ghist) begin
              shared_history <= hist_new;
            end
            if (flush) begin
              flush_count <= flush_count + 32'd1;
            end
            branch_count  <= branch_count + 32'd1;
            predict_taken <= 1'b0;
            predict_dest  <= '0;
          end else if (hit_q && cnt_old[1]) begin
            predict_taken <= 1'b1;
            predict_dest  <= etarget_q;
          end else begin
            predict_taken <= 1'b0;
            predict_dest  <= next_pc;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
